/* hw/rtl/bvm_pkg.sv */
package bvm_pkg;

	localparam int ADC_MV_W  = 13;
	localparam int ADC_CNT_W = 12;
	localparam int MV_W      = 13;
	localparam int SCALE_W   = 10;
	localparam int CELL_W    = 16;
	localparam int PCT_W     = 7;
	localparam int RUN_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 13;

	localparam int BURST_LEN_DEF = 16;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FULL_CHARGE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_THR     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CRIT_THR    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_NUM   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_DEN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ENFORCE     = 3'd5;

	localparam logic [MV_W-1:0]    FULL_CHARGE_RST = 13'd4200;
	localparam logic [MV_W-1:0]    LOW_THR_RST     = 13'd3500;
	localparam logic [MV_W-1:0]    CRIT_THR_RST    = 13'd3300;
	localparam logic [SCALE_W-1:0] SCALE_NUM_RST   = 10'd2;
	localparam logic [SCALE_W-1:0] SCALE_DEN_RST   = 10'd1;

	localparam logic [MV_W-1:0] CELL_MIN_MV = 13'd2800;
	localparam logic [MV_W-1:0] CELL_MAX_MV = 13'd4350;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam logic [RUN_W-1:0] RUN_MAX  = 8'd255;
	localparam logic [RUN_W-1:0] VALID_RUN_MIN = 8'd3;
	localparam logic [RUN_W-1:0] CRIT_RUN_MIN  = 8'd2;

	localparam int NUM_SEG = 10;

	// lipo discharge curve, highest segment first
	localparam logic [MV_W-1:0] SEG_EDGE [NUM_SEG] = '{
		13'd4050, 13'd3950, 13'd3850, 13'd3780, 13'd3720,
		13'd3680, 13'd3620, 13'd3550, 13'd3450, 13'd3300
	};
	localparam logic [PCT_W-1:0] SEG_BASE [NUM_SEG] = '{
		7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd0
	};
	localparam logic [MV_W-1:0] SEG_SPAN [NUM_SEG] = '{
		13'd0, 13'd100, 13'd100, 13'd70, 13'd60,
		13'd40, 13'd60, 13'd70, 13'd100, 13'd150
	};

endpackage

/* hw/rtl/bvm_ifs.sv */
interface bvm_adc_if;
	import bvm_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ADC_MV_W-1:0]  adc_millivolts;
	logic [ADC_CNT_W-1:0] adc_count;

	modport source (output valid, output adc_millivolts, output adc_count, input ready);
	modport sink   (input valid, input adc_millivolts, input adc_count, output ready);
endinterface

interface bvm_status_if;
	import bvm_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CELL_W-1:0]    cell_mv;
	logic [PCT_W-1:0]     charge_percent;
	logic                 available;
	logic                 low_flag;
	logic                 critical_flag;
	logic [ADC_MV_W-1:0]  avg_adc_mv;
	logic [ADC_CNT_W-1:0] avg_adc_count;

	modport source (
		output valid, output cell_mv, output charge_percent, output available,
		output low_flag, output critical_flag, output avg_adc_mv, output avg_adc_count,
		input ready
	);
	modport sink (
		input valid, input cell_mv, input charge_percent, input available,
		input low_flag, input critical_flag, input avg_adc_mv, input avg_adc_count,
		output ready
	);
endinterface

/* hw/rtl/battery_voltage_monitor.sv */
// Battery voltage monitor for a single lipo cell.
// adc: one conversion per transaction (calibrated millivolts and raw count).
// status: one transaction per burst of BURST_LEN conversions, carrying the
// averaged conversions, the reconstructed cell voltage, charge percent and flags.
// cfg: write enable, register index and data; it is to be written by the user
// only while the block idles, which the block itself does not enforce. A
// conversion that does not close a burst leaves the block idle, ready for the
// next. The conversion that closes a burst starts a sequence on one shared
// restoring divider (one quotient bit per cycle, DIV_W = 23 bits) and a
// shift-add multiplier (one numerator bit per cycle): two averages, the
// scaling, a segment lookup and the percent interpolation. adc.ready is low
// during that sequence.
// The result sits in an output register; the next burst is collected while it
// waits, and only the end of that next burst waits for status.ready.
// Reset clears the sums, burst position, run counters and the output valid,
// and loads the configuration defaults.
module battery_voltage_monitor #(
	parameter int BURST_LEN = bvm_pkg::BURST_LEN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bvm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bvm_pkg::CFG_W-1:0]      cfg_data,
	bvm_adc_if.sink                        adc,
	bvm_status_if.source                   status
);
	import bvm_pkg::*;

	localparam int POS_W     = (BURST_LEN > 1) ? $clog2(BURST_LEN) : 1;
	localparam int MV_SUM_W  = ADC_MV_W + $clog2(BURST_LEN);
	localparam int CNT_SUM_W = ADC_CNT_W + $clog2(BURST_LEN);
	localparam int PROD_W    = ADC_MV_W + SCALE_W;
	localparam int DIV_W     = (MV_SUM_W > PROD_W) ? MV_SUM_W : PROD_W;
	localparam int DEN_W     = MV_W;
	localparam int DCNT_W    = $clog2(DIV_W + 1);
	localparam int MCNT_W    = $clog2(SCALE_W + 1);
	localparam int TENS_W    = MV_W + 4;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DIV_MV   = 3'd1;
	localparam logic [2:0] S_DIV_CNT  = 3'd2;
	localparam logic [2:0] S_MUL      = 3'd3;
	localparam logic [2:0] S_DIV_CELL = 3'd4;
	localparam logic [2:0] S_SEG      = 3'd5;
	localparam logic [2:0] S_DIV_PCT  = 3'd6;
	localparam logic [2:0] S_DONE     = 3'd7;

	// configuration
	logic [MV_W-1:0]    full_charge_q, low_thr_q, crit_thr_q;
	logic [SCALE_W-1:0] scale_num_q, scale_den_q;
	logic               enforce_q;

	logic [2:0]           state_q;
	logic [POS_W-1:0]     pos_q;
	logic [MV_SUM_W-1:0]  mv_sum_q;
	logic [CNT_SUM_W-1:0] cnt_sum_q;
	logic [RUN_W-1:0]     valid_run_q, crit_run_q;

	// divider (shared by the four divides) and multiplier
	logic [DIV_W-1:0]   div_num_q;
	logic [DEN_W-1:0]   div_rem_q, div_den_q;
	logic [DCNT_W-1:0]  div_cnt_q;
	logic [PROD_W-1:0]  prod_q;
	logic [SCALE_W-1:0] mplier_q;
	logic [MCNT_W-1:0]  mul_cnt_q;

	logic [ADC_MV_W-1:0]  avg_mv_q;
	logic [ADC_CNT_W-1:0] avg_cnt_q;
	logic [DIV_W-1:0]     cell_q;
	logic                 cell_ok_q, pct_full_q, pct_zero_q;
	logic [PCT_W-1:0]     base_q;

	logic                 res_valid_q;
	logic [CELL_W-1:0]    res_cell_q;
	logic [PCT_W-1:0]     res_pct_q;
	logic                 res_avail_q, res_low_q, res_crit_q;
	logic [ADC_MV_W-1:0]  res_avg_mv_q;
	logic [ADC_CNT_W-1:0] res_avg_cnt_q;

	logic                 in_fire;
	logic [MV_SUM_W-1:0]  mv_sum_nxt;
	logic [CNT_SUM_W-1:0] cnt_sum_nxt;
	logic                 last_in_burst;

	assign in_fire       = adc.valid && adc.ready;
	assign adc.ready     = (state_q == S_IDLE);
	assign mv_sum_nxt    = mv_sum_q + MV_SUM_W'(adc.adc_millivolts);
	assign cnt_sum_nxt   = cnt_sum_q + CNT_SUM_W'(adc.adc_count);
	assign last_in_burst = (pos_q == POS_W'(BURST_LEN - 1));

	// one restoring step
	logic [DEN_W:0]   trial, trial_sub;
	logic             div_ge;
	logic [DEN_W-1:0] rem_nxt;
	logic [DIV_W-1:0] num_nxt;

	always_comb begin
		trial     = {div_rem_q, div_num_q[DIV_W-1]};
		trial_sub = trial - {1'b0, div_den_q};
		div_ge    = (trial >= {1'b0, div_den_q});
		rem_nxt   = div_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
		num_nxt   = {div_num_q[DIV_W-2:0], div_ge};
	end

	logic [DEN_W-1:0] den_eff;
	assign den_eff = (scale_den_q == '0) ? DEN_W'(1) : DEN_W'(scale_den_q);

	// segment lookup on the reconstructed cell voltage
	logic [MV_W-1:0]   cell_mv13, seg_edge, seg_span, seg_diff;
	logic [PCT_W-1:0]  seg_base;
	logic              seg_hit, cell_ok, at_full;
	logic [TENS_W-1:0] seg_tens;

	always_comb begin
		cell_mv13 = cell_q[MV_W-1:0];
		seg_hit   = 1'b0;
		seg_edge  = '0;
		seg_base  = '0;
		seg_span  = '0;
		for (int i = NUM_SEG - 1; i >= 0; i--) begin
			if (cell_mv13 >= SEG_EDGE[i]) begin
				seg_hit  = 1'b1;
				seg_edge = SEG_EDGE[i];
				seg_base = SEG_BASE[i];
				// top segment stretches up to the full charge register
				seg_span = (i == 0) ? (full_charge_q - SEG_EDGE[0]) : SEG_SPAN[i];
			end
		end
		cell_ok  = (cell_q >= DIV_W'(CELL_MIN_MV)) && (cell_q <= DIV_W'(CELL_MAX_MV));
		at_full  = (cell_q >= DIV_W'(full_charge_q));
		seg_diff = cell_mv13 - seg_edge;
		seg_tens = (TENS_W'(seg_diff) << 3) + (TENS_W'(seg_diff) << 1);
	end

	// run counters and flags for the finished reading
	logic [RUN_W-1:0]  valid_run_nxt, crit_run_nxt;
	logic              is_crit, res_ready_slot;
	logic [CELL_W-1:0] cell_sat;

	always_comb begin
		is_crit       = cell_ok_q && (cell_q <= DIV_W'(crit_thr_q));
		valid_run_nxt = !cell_ok_q ? '0 :
		                (valid_run_q == RUN_MAX) ? valid_run_q : valid_run_q + 1'b1;
		crit_run_nxt  = !is_crit ? '0 :
		                (crit_run_q == RUN_MAX) ? crit_run_q : crit_run_q + 1'b1;
		cell_sat      = (|cell_q[DIV_W-1:CELL_W]) ? '1 : cell_q[CELL_W-1:0];
		res_ready_slot = !res_valid_q || status.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_charge_q <= FULL_CHARGE_RST;
			low_thr_q     <= LOW_THR_RST;
			crit_thr_q    <= CRIT_THR_RST;
			scale_num_q   <= SCALE_NUM_RST;
			scale_den_q   <= SCALE_DEN_RST;
			enforce_q     <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FULL_CHARGE: full_charge_q <= cfg_data[MV_W-1:0];
				REG_LOW_THR:     low_thr_q     <= cfg_data[MV_W-1:0];
				REG_CRIT_THR:    crit_thr_q    <= cfg_data[MV_W-1:0];
				REG_SCALE_NUM:   scale_num_q   <= cfg_data[SCALE_W-1:0];
				REG_SCALE_DEN:   scale_den_q   <= cfg_data[SCALE_W-1:0];
				REG_ENFORCE:     enforce_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			mv_sum_q    <= '0;
			cnt_sum_q   <= '0;
			valid_run_q <= '0;
			crit_run_q  <= '0;
			div_cnt_q   <= '0;
			mul_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// in S_DONE the output register is reloaded below instead
			if (res_valid_q && status.ready && (state_q != S_DONE)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (last_in_burst) begin
							pos_q     <= '0;
							mv_sum_q  <= '0;
							cnt_sum_q <= cnt_sum_nxt;
							div_num_q <= DIV_W'(mv_sum_nxt);
							div_den_q <= DEN_W'(BURST_LEN);
							div_rem_q <= '0;
							div_cnt_q <= DCNT_W'(DIV_W);
							state_q   <= S_DIV_MV;
						end else begin
							pos_q     <= pos_q + 1'b1;
							mv_sum_q  <= mv_sum_nxt;
							cnt_sum_q <= cnt_sum_nxt;
						end
					end
				end
				S_DIV_MV, S_DIV_CNT, S_DIV_CELL, S_DIV_PCT: begin
					if (div_cnt_q != '0) begin
						div_num_q <= num_nxt;
						div_rem_q <= rem_nxt;
						div_cnt_q <= div_cnt_q - 1'b1;
					end else begin
						case (state_q)
							S_DIV_MV: begin
								avg_mv_q  <= div_num_q[ADC_MV_W-1:0];
								div_num_q <= DIV_W'(cnt_sum_q);
								cnt_sum_q <= '0;
								div_rem_q <= '0;
								div_cnt_q <= DCNT_W'(DIV_W);
								state_q   <= S_DIV_CNT;
							end
							S_DIV_CNT: begin
								avg_cnt_q <= div_num_q[ADC_CNT_W-1:0];
								prod_q    <= '0;
								mplier_q  <= scale_num_q;
								mul_cnt_q <= MCNT_W'(SCALE_W);
								state_q   <= S_MUL;
							end
							S_DIV_CELL: begin
								cell_q  <= div_num_q;
								state_q <= S_SEG;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_MUL: begin
					if (mul_cnt_q != '0) begin
						prod_q    <= (prod_q << 1) +
						             (mplier_q[SCALE_W-1] ? PROD_W'(avg_mv_q) : '0);
						mplier_q  <= mplier_q << 1;
						mul_cnt_q <= mul_cnt_q - 1'b1;
					end else begin
						// rounding half of the denominator before the divide
						div_num_q <= DIV_W'(prod_q) + DIV_W'(den_eff >> 1);
						div_den_q <= den_eff;
						div_rem_q <= '0;
						div_cnt_q <= DCNT_W'(DIV_W);
						state_q   <= S_DIV_CELL;
					end
				end
				S_SEG: begin
					cell_ok_q  <= cell_ok;
					pct_full_q <= cell_ok && (at_full || (seg_hit && seg_span == '0));
					pct_zero_q <= !cell_ok || !seg_hit;
					base_q     <= seg_base;
					div_num_q  <= DIV_W'(seg_tens);
					div_den_q  <= seg_span;
					div_rem_q  <= '0;
					div_cnt_q  <= DCNT_W'(DIV_W);
					state_q    <= S_DIV_PCT;
				end
				S_DONE: begin
					if (res_ready_slot) begin
						valid_run_q   <= valid_run_nxt;
						crit_run_q    <= crit_run_nxt;
						res_valid_q   <= 1'b1;
						res_cell_q    <= cell_sat;
						res_pct_q     <= pct_full_q ? PCT_FULL :
						                 pct_zero_q ? '0 : base_q + div_num_q[PCT_W-1:0];
						res_avail_q   <= cell_ok_q;
						res_low_q     <= cell_ok_q && (cell_q <= DIV_W'(low_thr_q));
						res_crit_q    <= enforce_q && is_crit &&
						                 (valid_run_nxt >= VALID_RUN_MIN) &&
						                 (crit_run_nxt >= CRIT_RUN_MIN);
						res_avg_mv_q  <= avg_mv_q;
						res_avg_cnt_q <= avg_cnt_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign status.valid          = res_valid_q;
	assign status.cell_mv        = res_cell_q;
	assign status.charge_percent = res_pct_q;
	assign status.available      = res_avail_q;
	assign status.low_flag       = res_low_q;
	assign status.critical_flag  = res_crit_q;
	assign status.avg_adc_mv     = res_avg_mv_q;
	assign status.avg_adc_count  = res_avg_cnt_q;

endmodule

/* hw/rtl/bvm_checker.sv */
module bvm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            res_valid,
	input logic                            res_ready,
	input logic [bvm_pkg::CELL_W-1:0]      cell_mv,
	input logic [bvm_pkg::PCT_W-1:0]       charge_percent,
	input logic                            available,
	input logic                            low_flag,
	input logic                            critical_flag
);
	import bvm_pkg::*;

	// a pending result transaction holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(cell_mv) && $stable(charge_percent))
		else $error("status transaction dropped or changed while stalled");

	// an unavailable reading carries no percent and no flags
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !available |-> charge_percent == '0 && !low_flag && !critical_flag)
		else $error("flags or percent set on an invalid reading");

	// an available reading lies in the valid cell range
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && available |->
			cell_mv >= CELL_W'(CELL_MIN_MV) && cell_mv <= CELL_W'(CELL_MAX_MV))
		else $error("available reading outside the cell range");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> charge_percent <= PCT_FULL)
		else $error("charge percent above full");

endmodule

bind battery_voltage_monitor bvm_checker u_bvm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (status.valid),
	.res_ready      (status.ready),
	.cell_mv        (status.cell_mv),
	.charge_percent (status.charge_percent),
	.available      (status.available),
	.low_flag       (status.low_flag),
	.critical_flag  (status.critical_flag)
);
